/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Payload widths of the channels
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_IN_W   = 7;
  localparam int unsigned LINE_IN_W  = 5;
  localparam int unsigned CUR_OUT_W  = 11;

  // Widest cell address the grid limits allow (128 x 32 cells)
  localparam int unsigned ADDR_MAX_W = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 1'b1;

  localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [BYTE_W-1:0] ERROR_ATTR_RST   = 8'd244;

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_ERROR   = 8'd69;  // 'E'
  localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'd0;

  typedef enum logic [FUNC_W-1:0] {
    FN_PRINT  = 3'd0,
    FN_WRITE  = 3'd1,
    FN_SETCUR = 3'd2,
    FN_READ   = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef struct packed {
    logic [BYTE_W-1:0] default_attr;
    logic [BYTE_W-1:0] error_attr;
  } cfg_t;

  // One write beat into the cell memories
  typedef struct packed {
    logic                  char_en;
    logic                  attr_en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [BYTE_W-1:0]     ch;
    logic [BYTE_W-1:0]     attr;
  } mem_wr_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
  } mem_rd_t;

  // Attribute zero selects the default attribute
  function automatic logic [BYTE_W-1:0] pick_attr(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] dflt);
    return (a != '0) ? a : dflt;
  endfunction

endpackage

/* rtl/tcw_if.sv */
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: request and response.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [BYTE_W-1:0]    char_code;
  logic [BYTE_W-1:0]    attribute;
  logic [COL_IN_W-1:0]  column;
  logic [LINE_IN_W-1:0] line;

  modport source (output valid, func, char_code, attribute, column, line,
                  input ready);
  modport sink (input valid, func, char_code, attribute, column, line,
                output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    read_char;
  logic [BYTE_W-1:0]    read_attribute;
  logic [CUR_OUT_W-1:0] cursor_position;
  logic                 out_of_range;

  modport source (output valid, read_char, read_attribute, cursor_position,
                  out_of_range, input ready);
  modport sink (input valid, read_char, read_attribute, cursor_position,
                out_of_range, output ready);
endinterface

/* rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor tracking, cell access, scroll copy, clear sweep,
// and the response register.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  tcw_req_if.sink           req,
  tcw_rsp_if.source         rsp,
  output mem_wr_t           mem_wr_o,
  output mem_rd_t           mem_rd_o,
  input  logic [BYTE_W-1:0] rd_char_i,
  input  logic [BYTE_W-1:0] rd_attr_i
);

  localparam int unsigned NCELLS = COLS * ROWS;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned LW     = $clog2(NCELLS + 1);
  localparam int unsigned RW     = $clog2(ROWS + 1);
  localparam int unsigned CW     = $clog2(COLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FILL,
    S_CLEAR,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [FUNC_W-1:0]     func_q, func_d;
  logic [BYTE_W-1:0]     char_q, char_d;
  logic [BYTE_W-1:0]     attr_q, attr_d;
  logic [COL_IN_W-1:0]   col_in_q, col_in_d;
  logic [LINE_IN_W-1:0]  line_in_q, line_in_d;
  logic [RW-1:0]         cur_row_q, cur_row_d;
  logic [CW-1:0]         cur_col_q, cur_col_d;
  logic [LW-1:0]         cur_lin_q, cur_lin_d;
  logic [LW-1:0]         scan_q, scan_d;
  logic                  wr_pend_q, wr_pend_d;
  logic [AW-1:0]         wr_addr_q, wr_addr_d;
  logic                  rd_hit_q, rd_hit_d;
  logic                  oor_q, oor_d;
  logic                  out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]     out_char_q, out_char_d;
  logic [BYTE_W-1:0]     out_attr_q, out_attr_d;
  logic [CUR_OUT_W-1:0]  out_cur_q, out_cur_d;
  logic                  out_oor_q, out_oor_d;

  logic                  accept;
  logic                  can_load;
  logic                  in_grid;
  logic [ADDR_MAX_W-1:0] pos;

  assign can_load  = !out_valid_q || rsp.ready;
  assign req.ready = (state_q == S_IDLE) || ((state_q == S_RESP) && can_load);
  assign accept    = req.valid && req.ready;

  assign in_grid = (8'(col_in_q) < 8'(COLS)) && (6'(line_in_q) < 6'(ROWS));
  assign pos     = ADDR_MAX_W'(ADDR_MAX_W'(line_in_q) * ADDR_MAX_W'(COLS)
                               + ADDR_MAX_W'(col_in_q));

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    char_d      = char_q;
    attr_d      = attr_q;
    col_in_d    = col_in_q;
    line_in_d   = line_in_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    cur_lin_d   = cur_lin_q;
    scan_d      = scan_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    rd_hit_d    = rd_hit_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    out_cur_d   = out_cur_q;
    out_oor_d   = out_oor_q;
    mem_wr_o    = '0;
    mem_rd_o    = '0;

    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        oor_d    = 1'b0;
        rd_hit_d = 1'b0;
        state_d  = S_RESP;
        case (func_q)
          FN_PRINT: begin
            if (cur_row_q == RW'(ROWS)) begin
              // Past the last row: scroll first, then come back to print
              cur_row_d = RW'(ROWS - 1);
              cur_col_d = '0;
              cur_lin_d = LW'(NCELLS - COLS);
              scan_d    = LW'(COLS);
              wr_pend_d = 1'b0;
              state_d   = S_SCROLL;
            end else if (char_q == CHAR_NEWLINE) begin
              cur_row_d = cur_row_q + RW'(1);
              cur_col_d = '0;
              cur_lin_d = cur_lin_q - LW'(cur_col_q) + LW'(COLS);
            end else begin
              mem_wr_o.char_en = 1'b1;
              mem_wr_o.attr_en = 1'b1;
              mem_wr_o.addr    = ADDR_MAX_W'(cur_lin_q[AW-1:0]);
              mem_wr_o.ch      = char_q;
              mem_wr_o.attr    = pick_attr(attr_q, cfg_i.default_attr);
              cur_lin_d        = cur_lin_q + LW'(1);
              if (cur_col_q == CW'(COLS - 1)) begin
                cur_col_d = '0;
                cur_row_d = cur_row_q + RW'(1);
              end else begin
                cur_col_d = cur_col_q + CW'(1);
              end
            end
          end
          FN_WRITE: begin
            mem_wr_o.char_en = 1'b1;
            mem_wr_o.attr_en = 1'b1;
            if (in_grid) begin
              mem_wr_o.addr = pos;
              mem_wr_o.ch   = char_q;
              mem_wr_o.attr = pick_attr(attr_q, cfg_i.default_attr);
            end else begin
              mem_wr_o.addr = ADDR_MAX_W'(NCELLS - 1);
              mem_wr_o.ch   = CHAR_ERROR;
              mem_wr_o.attr = pick_attr(cfg_i.error_attr, cfg_i.default_attr);
              oor_d         = 1'b1;
            end
          end
          FN_SETCUR: begin
            if (in_grid) begin
              cur_row_d = RW'(line_in_q);
              cur_col_d = CW'(col_in_q);
              cur_lin_d = LW'(pos);
            end else begin
              oor_d = 1'b1;
            end
          end
          FN_READ: begin
            if (in_grid) begin
              mem_rd_o.en   = 1'b1;
              mem_rd_o.addr = pos;
              rd_hit_d      = 1'b1;
            end else begin
              oor_d = 1'b1;
            end
          end
          FN_CLEAR: begin
            scan_d  = '0;
            state_d = S_CLEAR;
          end
          default: ;
        endcase
      end

      // Copy rows 1.. up by one row: read one cell a beat, write it COLS lower
      // on the next beat
      S_SCROLL: begin
        if (wr_pend_q) begin
          mem_wr_o.char_en = 1'b1;
          mem_wr_o.attr_en = 1'b1;
          mem_wr_o.addr    = ADDR_MAX_W'(wr_addr_q);
          mem_wr_o.ch      = rd_char_i;
          mem_wr_o.attr    = rd_attr_i;
        end
        if (scan_q != LW'(NCELLS)) begin
          mem_rd_o.en   = 1'b1;
          mem_rd_o.addr = ADDR_MAX_W'(scan_q[AW-1:0]);
          wr_addr_d     = AW'(scan_q - LW'(COLS));
          wr_pend_d     = 1'b1;
          scan_d        = scan_q + LW'(1);
        end else begin
          wr_pend_d = 1'b0;
          scan_d    = LW'(NCELLS - COLS);
          state_d   = S_FILL;
        end
      end

      S_FILL: begin
        mem_wr_o.char_en = 1'b1;
        mem_wr_o.attr_en = 1'b1;
        mem_wr_o.addr    = ADDR_MAX_W'(scan_q[AW-1:0]);
        mem_wr_o.ch      = CHAR_BLANK;
        mem_wr_o.attr    = cfg_i.default_attr;
        scan_d           = scan_q + LW'(1);
        if (scan_q == LW'(NCELLS - 1)) begin
          state_d = S_EXEC;
        end
      end

      // Characters only; attributes live in their own memory and stay put
      S_CLEAR: begin
        mem_wr_o.char_en = 1'b1;
        mem_wr_o.addr    = ADDR_MAX_W'(scan_q[AW-1:0]);
        mem_wr_o.ch      = CHAR_SPACE;
        scan_d           = scan_q + LW'(1);
        if (scan_q == LW'(NCELLS - 1)) begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_char_d  = rd_hit_q ? rd_char_i : '0;
          out_attr_d  = rd_hit_q ? rd_attr_i : '0;
          out_cur_d   = CUR_OUT_W'(cur_lin_q);
          out_oor_d   = oor_q;
          state_d     = accept ? S_EXEC : S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (accept) begin
      func_d    = req.func;
      char_d    = req.char_code;
      attr_d    = req.attribute;
      col_in_d  = req.column;
      line_in_d = req.line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= '0;
      char_q      <= '0;
      attr_q      <= '0;
      col_in_q    <= '0;
      line_in_q   <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cur_lin_q   <= '0;
      scan_q      <= '0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      rd_hit_q    <= 1'b0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_attr_q  <= '0;
      out_cur_q   <= '0;
      out_oor_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      char_q      <= char_d;
      attr_q      <= attr_d;
      col_in_q    <= col_in_d;
      line_in_q   <= line_in_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      cur_lin_q   <= cur_lin_d;
      scan_q      <= scan_d;
      wr_pend_q   <= wr_pend_d;
      wr_addr_q   <= wr_addr_d;
      rd_hit_q    <= rd_hit_d;
      oor_q       <= oor_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_attr_q  <= out_attr_d;
      out_cur_q   <= out_cur_d;
      out_oor_q   <= out_oor_d;
    end
  end

  assign rsp.valid           = out_valid_q;
  assign rsp.read_char       = out_char_q;
  assign rsp.read_attribute  = out_attr_q;
  assign rsp.cursor_position = out_cur_q;
  assign rsp.out_of_range    = out_oor_q;

`ifndef SYNTHESIS
  // Linear cursor always agrees with its row and column
  a_cursor_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_lin_q == LW'(LW'(cur_row_q) * LW'(COLS) + LW'(cur_col_q)))
    else $error("linear cursor out of step with row/column");

  // An accepted beat is always executed on the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted beat not executed");

  // No cell is written while the sequencer waits for work or for the sink
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESP) |-> !(mem_wr_o.char_en || mem_wr_o.attr_en))
    else $error("cell write outside an operation");

  // A response appears only out of the response state
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp.valid) |-> $past(state_q == S_RESP))
    else $error("response raised outside response state");
`endif

endmodule

/* rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Character/attribute cell grid with cursor, wrap, newline, scroll and clear.
//
//   channel  dir  handshake           payload
//   req      in   req.valid/ready     func, char_code, attribute, column, line
//   rsp      out  rsp.valid/ready     read_char, read_attribute,
//                                     cursor_position, out_of_range
//   cfg      in   cfg_we_i            cfg_idx_i, cfg_data_i
//
// Print, write, set-cursor and read pass an execute and a respond state. A print
// that scrolls copies rows up and blanks the last row; a clear sweeps all cells.
// Both are bound by the single write port of the cell memories (one cell/cycle).
// Reset zeroes cursor and state, loads cfg defaults; cells undefined until written.
// The next item is taken while a response waits; a stalled response holds the
// sequencer in its response state.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  tcw_req_if.sink              req,
  tcw_rsp_if.source            rsp
);

  localparam int unsigned NCELLS = COLS * ROWS;
  localparam int unsigned AW     = $clog2(NCELLS);

  cfg_t              cfg_q;
  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [BYTE_W-1:0] rd_char;
  logic [BYTE_W-1:0] rd_attr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_attr <= DEFAULT_ATTR_RST;
      cfg_q.error_attr   <= ERROR_ATTR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEFAULT_ATTR: cfg_q.default_attr <= cfg_data_i;
        CFG_ERROR_ATTR:   cfg_q.error_attr   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .req       (req),
    .rsp       (rsp),
    .mem_wr_o  (mem_wr),
    .mem_rd_o  (mem_rd),
    .rd_char_i (rd_char),
    .rd_attr_i (rd_attr)
  );

  // Characters and attributes in separate memories so a clear touches only
  // the characters
  tcw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NCELLS)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.char_en),
    .waddr_i (mem_wr.addr[AW-1:0]),
    .wdata_i (mem_wr.ch),
    .re_i    (mem_rd.en),
    .raddr_i (mem_rd.addr[AW-1:0]),
    .rdata_o (rd_char)
  );

  tcw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NCELLS)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_wr.attr_en),
    .waddr_i (mem_wr.addr[AW-1:0]),
    .wdata_i (mem_wr.attr),
    .re_i    (mem_rd.en),
    .raddr_i (mem_rd.addr[AW-1:0]),
    .rdata_o (rd_attr)
  );

endmodule
